### src/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg: shared types and constants for the circle contain/project core
// Widths, pipeline words and the saturation helper used across the block.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int MAG_W  = COORD_BITS + 1;   // signed delta / magnitude
  localparam int SQ_W   = 2 * MAG_W;        // sum of squares
  localparam int ROOT_W = MAG_W;            // floor sqrt
  localparam int RD_W   = ROOT_W + 1;       // radius - distance
  localparam int PROD_W = RD_W + MAG_W;
  localparam int NUM_W  = PROD_W + 1;       // 2*prod + d
  localparam int QUO_W  = RD_W + 1;         // offset magnitude
  localparam int DVS_W  = ROOT_W + 1;       // divisor 2*d
  localparam int SUM_W  = QUO_W + 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] probe_x;
    logic signed [COORD_BITS-1:0] probe_y;
  } in_word_t;

  typedef struct packed {
    logic                         inside_res;
    logic signed [COORD_BITS-1:0] closest_x;
    logic signed [COORD_BITS-1:0] closest_y;
  } res_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [MAG_W-1:0]      dx;   // two's complement
    logic [MAG_W-1:0]      dy;
  } carry_t;

  typedef struct packed {
    carry_t            c;
    logic [SQ_W-1:0]   s;
    logic [ROOT_W:0]   r;
    logic [ROOT_W-1:0] q;
  } sqrt_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  in_circle;
    logic                  zero;
    logic                  neg_x;
    logic                  neg_y;
    logic [DVS_W-1:0]      dvs;
    logic [DVS_W-1:0]      rem_x;
    logic [DVS_W-1:0]      rem_y;
    logic [QUO_W-1:0]      nlo_x;
    logic [QUO_W-1:0]      nlo_y;
    logic [QUO_W-1:0]      q_x;
    logic [QUO_W-1:0]      q_y;
  } div_t;

  // clamp a wide two's complement value to the coordinate range
  function automatic logic [COORD_BITS-1:0] sat(input logic [SUM_W-1:0] v);
    logic [SUM_W-COORD_BITS:0] top;
    top = v[SUM_W-1:COORD_BITS-1];
    if (!v[SUM_W-1] && (top != '0)) begin
      sat = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (v[SUM_W-1] && (top != '1)) begin
      sat = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat = v[COORD_BITS-1:0];
    end
  endfunction

endpackage

### src/circle_contain_and_project_core.sv
// ----------------------------------------------------------------------------
// circle_contain_and_project_core: circle containment test and projection
// Tests a Q16.16 probe against the configured circle and returns the nearest
// point on that circle.
// ----------------------------------------------------------------------------
// A new probe word is taken every clock cycle (busy never rises), and its
// result shows up on result_o with done_o high for one cycle, after it has
// passed the front end, the bit-per-stage square root (one stage per root
// bit), the offset setup, the bit-per-stage offset divider (one stage per
// quotient bit) and the output register.
// Results leave in input order and cannot be held off: capture them when
// done_o is high. Change center or radius only with the pipeline empty.
// ----------------------------------------------------------------------------
module circle_contain_and_project_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  ccp_pkg::in_word_t                  word_i,
  output logic                               done_o,
  output ccp_pkg::res_word_t                 result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ccp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ccp_pkg::COORD_BITS-1:0]     cfg_data_i
);
  localparam int CW = ccp_pkg::COORD_BITS;
  localparam int RW = ccp_pkg::ROOT_W;
  localparam int QW = ccp_pkg::QUO_W;
  localparam int SW = ccp_pkg::SUM_W;

  // config registers
  logic [CW-1:0] center_x_q, center_y_q;
  logic [CW-2:0] radius_q;

  // pipeline never stalls; the receiver cannot push back
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= (CW-1)'(1) << ccp_pkg::FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ccp_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i;
        ccp_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i;
        ccp_pkg::CFG_RADIUS:   radius_q   <= cfg_data_i[CW-2:0];
        default: ;             // unmapped index: ignored
      endcase
    end
  end

  // front end: delta, squares, sum
  logic           sq_v [0:RW];
  ccp_pkg::sqrt_t sq_w [0:RW];

  ccp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start & ~busy),
    .word_i     (word_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (sq_v[0]),
    .sqrt_o     (sq_w[0])
  );

  // square root: one stage per root bit
  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    ccp_sqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .sqrt_i  (sq_w[i]),
      .valid_o (sq_v[i+1]),
      .sqrt_o  (sq_w[i+1])
    );
  end

  // radius - d, products, numerator
  logic          dv_v [0:QW];
  ccp_pkg::div_t dv_w [0:QW];

  ccp_mid u_mid (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_v[RW]),
    .sqrt_i   (sq_w[RW]),
    .radius_i (radius_q),
    .valid_o  (dv_v[0]),
    .div_o    (dv_w[0])
  );

  // offset division: one stage per quotient bit, both axes side by side
  for (genvar j = 0; j < QW; j++) begin : g_div
    ccp_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[j]),
      .div_i   (dv_w[j]),
      .valid_o (dv_v[j+1]),
      .div_o   (dv_w[j+1])
    );
  end

  // final: apply signed offset, saturate; probe at center goes along +x
  ccp_pkg::div_t      fin;
  logic [SW-1:0]      px_ext, py_ext, offx, offy, sumx, sumy;
  ccp_pkg::res_word_t res_d, res_q;
  logic               done_q;

  always_comb begin
    fin    = dv_w[QW];
    px_ext = {{(SW-CW){fin.px[CW-1]}}, fin.px};
    py_ext = {{(SW-CW){fin.py[CW-1]}}, fin.py};
    offx   = {{(SW-QW){1'b0}}, fin.q_x};
    offy   = {{(SW-QW){1'b0}}, fin.q_y};
    if (fin.neg_x) offx = ~offx + 1'b1;
    if (fin.neg_y) offy = ~offy + 1'b1;
    if (fin.zero) begin
      sumx = px_ext + {{(SW-CW+1){1'b0}}, radius_q};
      sumy = py_ext;
    end else begin
      sumx = px_ext + offx;
      sumy = py_ext + offy;
    end
    res_d.inside_res = fin.in_circle;
    res_d.closest_x  = ccp_pkg::sat(sumx);
    res_d.closest_y  = ccp_pkg::sat(sumy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;
endmodule

### src/ccp_front.sv
// ----------------------------------------------------------------------------
// ccp_front: displacement and squared length
// Three stages: delta from center, squares, sum.
// ----------------------------------------------------------------------------
module ccp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  ccp_pkg::in_word_t                   word_i,
  input  logic [ccp_pkg::COORD_BITS-1:0]      center_x_i,
  input  logic [ccp_pkg::COORD_BITS-1:0]      center_y_i,
  output logic                                valid_o,
  output ccp_pkg::sqrt_t                      sqrt_o
);
  localparam int CW = ccp_pkg::COORD_BITS;
  localparam int MW = ccp_pkg::MAG_W;

  logic            v0_q, v1_q, v2_q;
  ccp_pkg::carry_t c0_d, c0_q, c1_q;
  logic [MW-1:0]   mx, my;
  logic [2*MW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  ccp_pkg::sqrt_t  s2_d, s2_q;

  always_comb begin
    c0_d.px = word_i.probe_x;
    c0_d.py = word_i.probe_y;
    c0_d.dx = {word_i.probe_x[CW-1], word_i.probe_x} - {center_x_i[CW-1], center_x_i};
    c0_d.dy = {word_i.probe_y[CW-1], word_i.probe_y} - {center_y_i[CW-1], center_y_i};
  end

  always_comb begin
    mx = c0_q.dx[MW-1] ? (~c0_q.dx + 1'b1) : c0_q.dx;
    my = c0_q.dy[MW-1] ? (~c0_q.dy + 1'b1) : c0_q.dy;
    sqx_d = mx * mx;
    sqy_d = my * my;
  end

  always_comb begin
    s2_d.c = c1_q;
    s2_d.s = sqx_q + sqy_q;
    s2_d.r = '0;
    s2_d.q = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q  <= c0_d;
    c1_q  <= c0_q;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    s2_q  <= s2_d;
  end

  assign valid_o = v2_q;
  assign sqrt_o  = s2_q;
endmodule

### src/ccp_sqrt_step.sv
// ----------------------------------------------------------------------------
// ccp_sqrt_step: one root bit of the digit-by-digit square root
// Brings down two radicand bits, trial subtract, registers the result.
// ----------------------------------------------------------------------------
module ccp_sqrt_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  ccp_pkg::sqrt_t sqrt_i,
  output logic           valid_o,
  output ccp_pkg::sqrt_t sqrt_o
);
  localparam int RW = ccp_pkg::ROOT_W;
  localparam int SW = ccp_pkg::SQ_W;

  logic [RW+3:0]  acc, trial;
  ccp_pkg::sqrt_t s_d, s_q;
  logic           v_q;

  always_comb begin
    acc   = {sqrt_i.r, sqrt_i.s[SW-1 -: 2]};
    trial = acc - {1'b0, sqrt_i.q, 2'b01};
    s_d.c = sqrt_i.c;
    s_d.s = {sqrt_i.s[SW-3:0], 2'b00};
    if (!trial[RW+3]) begin
      s_d.r = trial[RW:0];
      s_d.q = {sqrt_i.q[RW-2:0], 1'b1};
    end else begin
      s_d.r = acc[RW:0];
      s_d.q = {sqrt_i.q[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  assign valid_o = v_q;
  assign sqrt_o  = s_q;
endmodule

### src/ccp_mid.sv
// ----------------------------------------------------------------------------
// ccp_mid: offset numerator setup
// Three stages: radius minus distance, products, numerator and divider seed.
// ----------------------------------------------------------------------------
module ccp_mid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  ccp_pkg::sqrt_t                     sqrt_i,
  input  logic [ccp_pkg::COORD_BITS-2:0]     radius_i,
  output logic                               valid_o,
  output ccp_pkg::div_t                      div_o
);
  localparam int CW = ccp_pkg::COORD_BITS;
  localparam int MW = ccp_pkg::MAG_W;
  localparam int RW = ccp_pkg::ROOT_W;
  localparam int DW = ccp_pkg::RD_W;
  localparam int PW = ccp_pkg::PROD_W;
  localparam int NW = ccp_pkg::NUM_W;
  localparam int QW = ccp_pkg::QUO_W;
  localparam int VW = ccp_pkg::DVS_W;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic          in_circle;
    logic          zero;
    logic          neg_x;
    logic          neg_y;
    logic [RW-1:0] d;
  } tag_t;

  logic          v0_q, v1_q, v2_q;
  tag_t          t0_d, t0_q, t1_q;
  logic [DW-1:0] rd, rdm_d, rdm_q;
  logic [MW-1:0] mx_d, my_d, mx_q, my_q;
  logic [PW-1:0] px_d, py_d, px_q, py_q;
  logic [NW-1:0] nx, ny;
  ccp_pkg::div_t dv_d, dv_q;

  always_comb begin
    rd   = {{(DW-CW+1){1'b0}}, radius_i} - {1'b0, sqrt_i.q};
    rdm_d = rd[DW-1] ? (~rd + 1'b1) : rd;
    mx_d = sqrt_i.c.dx[MW-1] ? (~sqrt_i.c.dx + 1'b1) : sqrt_i.c.dx;
    my_d = sqrt_i.c.dy[MW-1] ? (~sqrt_i.c.dy + 1'b1) : sqrt_i.c.dy;
    t0_d.px        = sqrt_i.c.px;
    t0_d.py        = sqrt_i.c.py;
    t0_d.in_circle = ({1'b0, sqrt_i.q} < {{(DW-CW+1){1'b0}}, radius_i});
    t0_d.zero      = (sqrt_i.q == '0);
    t0_d.neg_x     = rd[DW-1] ^ sqrt_i.c.dx[MW-1];
    t0_d.neg_y     = rd[DW-1] ^ sqrt_i.c.dy[MW-1];
    t0_d.d         = sqrt_i.q;
  end

  always_comb begin
    px_d = rdm_q * mx_q;
    py_d = rdm_q * my_q;
  end

  always_comb begin
    nx = {px_q, 1'b0} + {{(NW-RW){1'b0}}, t1_q.d};
    ny = {py_q, 1'b0} + {{(NW-RW){1'b0}}, t1_q.d};
    dv_d.px        = t1_q.px;
    dv_d.py        = t1_q.py;
    dv_d.in_circle = t1_q.in_circle;
    dv_d.zero      = t1_q.zero;
    dv_d.neg_x     = t1_q.neg_x;
    dv_d.neg_y     = t1_q.neg_y;
    dv_d.dvs       = {t1_q.d, 1'b0};
    dv_d.rem_x     = {{(VW-(NW-QW)){1'b0}}, nx[NW-1:QW]};
    dv_d.rem_y     = {{(VW-(NW-QW)){1'b0}}, ny[NW-1:QW]};
    dv_d.nlo_x     = nx[QW-1:0];
    dv_d.nlo_y     = ny[QW-1:0];
    dv_d.q_x       = '0;
    dv_d.q_y       = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q  <= t0_d;
    rdm_q <= rdm_d;
    mx_q  <= mx_d;
    my_q  <= my_d;
    t1_q  <= t0_q;
    px_q  <= px_d;
    py_q  <= py_d;
    dv_q  <= dv_d;
  end

  assign valid_o = v2_q;
  assign div_o   = dv_q;
endmodule

### src/ccp_div_step.sv
// ----------------------------------------------------------------------------
// ccp_div_step: one quotient bit for both axes
// Restoring division step against the shared divisor 2*d.
// ----------------------------------------------------------------------------
module ccp_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  ccp_pkg::div_t div_i,
  output logic          valid_o,
  output ccp_pkg::div_t div_o
);
  localparam int QW = ccp_pkg::QUO_W;
  localparam int VW = ccp_pkg::DVS_W;

  logic [VW:0]   shx, shy, dvx, dvy;
  ccp_pkg::div_t d_d, d_q;
  logic          v_q;

  always_comb begin
    d_d   = div_i;
    shx   = {div_i.rem_x, div_i.nlo_x[QW-1]};
    shy   = {div_i.rem_y, div_i.nlo_y[QW-1]};
    dvx   = shx - {1'b0, div_i.dvs};
    dvy   = shy - {1'b0, div_i.dvs};
    d_d.nlo_x = {div_i.nlo_x[QW-2:0], 1'b0};
    d_d.nlo_y = {div_i.nlo_y[QW-2:0], 1'b0};
    if (shx >= {1'b0, div_i.dvs}) begin
      d_d.rem_x = dvx[VW-1:0];
      d_d.q_x   = {div_i.q_x[QW-2:0], 1'b1};
    end else begin
      d_d.rem_x = shx[VW-1:0];
      d_d.q_x   = {div_i.q_x[QW-2:0], 1'b0};
    end
    if (shy >= {1'b0, div_i.dvs}) begin
      d_d.rem_y = dvy[VW-1:0];
      d_d.q_y   = {div_i.q_y[QW-2:0], 1'b1};
    end else begin
      d_d.rem_y = shy[VW-1:0];
      d_d.q_y   = {div_i.q_y[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end

  assign valid_o = v_q;
  assign div_o   = d_q;
endmodule

### dv/circle_contain_and_project_core_tb.sv
// ----------------------------------------------------------------------------
// circle_contain_and_project_core_tb: self-checking bench for the circle core
// Streams probe words through the core under several circle settings, predicts
// the inside flag and the nearest point on the circle, and checks every result.
// ----------------------------------------------------------------------------
module circle_contain_and_project_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = ccp_pkg::COORD_BITS;
  localparam int IW = ccp_pkg::CFG_IDX_W;
  // pipeline depth summed from the stage counts, plus margin
  localparam int PIPE_LAT  = 3 + ccp_pkg::ROOT_W + 3 + ccp_pkg::QUO_W + 1;
  localparam int DRAIN_CYC = PIPE_LAT + 10;
  localparam int STALL_MAX = 4000;
  localparam int MAX_SHOWN = 10;
  // index past the register list, the core must ignore it
  localparam logic [IW-1:0] CFG_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  ccp_pkg::in_word_t word_i = '0;
  logic done_o;
  ccp_pkg::res_word_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IW-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  circle_contain_and_project_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .word_i      (word_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // circle as the bench believes it is configured
  longint ctr_x = 0;
  longint ctr_y = 0;
  longint rad   = 64'd1 << ccp_pkg::FRAC_BITS;

  ccp_pkg::in_word_t  probe_q[$];        // probes waiting to be driven
  ccp_pkg::res_word_t closest_q[$];      // predicted results, oldest first
  int  mismatches = 0;
  int  stall_cnt  = 0;
  bit  gaps_on    = 1'b1;
  int  gap_left   = 0;

  function automatic logic [127:0] mag_of(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // (r - d) * comp / d, rounded half away from zero
  function automatic longint round_offset(longint rd, longint comp, logic [63:0] d);
    logic [127:0] num, q;
    num = 2 * mag_of(rd) * mag_of(comp) + 128'(d);
    q   = num / (128'(d) * 2);
    return ((rd < 0) != (comp < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic ccp_pkg::res_word_t project_probe(ccp_pkg::in_word_t w);
    longint px, py, dx, dy, rd;
    logic [127:0] sq, cand;
    logic [63:0] root;
    ccp_pkg::res_word_t r;
    px = longint'(w.probe_x);
    py = longint'(w.probe_y);
    dx = px - ctr_x;
    dy = py - ctr_y;
    sq = mag_of(dx) * mag_of(dx) + mag_of(dy) * mag_of(dy);
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      cand = 128'(root | (64'd1 << b));
      if (cand * cand <= sq) root = cand[63:0];
    end
    r.inside_res = (root < rad);
    if (root == 0) begin
      // probe on the center: direction defaults to +x
      r.closest_x = CW'(clamp_coord(px + rad));
      r.closest_y = CW'(clamp_coord(py));
    end else begin
      rd = rad - longint'(root);
      r.closest_x = CW'(clamp_coord(px + round_offset(rd, dx, root)));
      r.closest_y = CW'(clamp_coord(py + round_offset(rd, dy, root)));
    end
    return r;
  endfunction

  // driver: presents queued probes, random gaps between words while gaps_on is set
  always @(posedge clk_i) begin
    int pick;
    if (start && !busy) begin
      closest_q.push_back(project_probe(word_i));
      pick = $urandom_range(0, 99);
      if (!gaps_on || pick < 60) gap_left = 0;
      else if (pick < 95) gap_left = $urandom_range(1, 3);
      else gap_left = $urandom_range(10, 40);
    end
    if (start && busy) begin
      // hold the word until taken
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (probe_q.size() > 0) begin
      start  <= 1'b1;
      word_i <= probe_q.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: every done word is checked against the oldest prediction
  always @(posedge clk_i) begin
    ccp_pkg::res_word_t exp_w;
    if (rst_ni && done_o) begin
      if (closest_q.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("unexpected result %h", result_o);
        mismatches++;
      end else begin
        exp_w = closest_q.pop_front();
        if (exp_w.inside_res !== result_o.inside_res ||
            exp_w.closest_x !== result_o.closest_x ||
            exp_w.closest_y !== result_o.closest_y) begin
          if (mismatches < MAX_SHOWN)
            $display("mismatch: exp in=%0d x=%h y=%h got in=%0d x=%h y=%h",
                     exp_w.inside_res, exp_w.closest_x, exp_w.closest_y,
                     result_o.inside_res, result_o.closest_x, result_o.closest_y);
          mismatches++;
        end
      end
    end
  end

  // watchdog: no accepted word of any kind for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      ccp_pkg::CFG_CENTER_X: ctr_x = longint'($signed(data));
      ccp_pkg::CFG_CENTER_Y: ctr_y = longint'($signed(data));
      ccp_pkg::CFG_RADIUS:   rad   = longint'(data[CW-2:0]);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // wait for an empty pipe before touching the circle
  task automatic drain_pipe();
    while (probe_q.size() > 0 || start || closest_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic push_probe(logic [31:0] x, logic [31:0] y);
    ccp_pkg::in_word_t w;
    w.probe_x = x;
    w.probe_y = y;
    probe_q.push_back(w);
  endtask

  // mix of full-range probes and probes near the center / on the circle
  task automatic push_random(int n);
    int pick;
    logic [31:0] ofs;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        push_probe($urandom, $urandom);
      end else if (pick < 7) begin
        ofs = 32'($signed($urandom_range(0, 2 * 32'(rad) + 2)) - longint'(rad));
        push_probe(32'(ctr_x) + ofs, 32'(ctr_y) + 32'($signed($urandom_range(0, 4000)) - 2000));
      end else if (pick < 9) begin
        push_probe(32'(ctr_x) + 32'($signed($urandom_range(0, 65536)) - 32768),
                   32'(ctr_y) + 32'($signed($urandom_range(0, 65536)) - 32768));
      end else begin
        push_probe(32'(ctr_x) + 32'($signed($urandom_range(0, 8)) - 4), 32'(ctr_y));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset circle: unit radius at the origin, directed corners first
    push_probe(32'h0, 32'h0);                 // on the center
    push_probe(32'h0001_0000, 32'h0);         // on the circle
    push_probe(32'h0000_ffff, 32'h0);         // just inside
    push_probe(32'h0, 32'hffff_0000);         // on the circle, -y
    push_probe(32'h7fff_ffff, 32'h7fff_ffff);
    push_probe(32'h8000_0000, 32'h8000_0000);
    push_probe(32'h7fff_ffff, 32'h8000_0000);
    push_probe(32'h8000_0000, 32'h7fff_ffff);
    push_probe(32'h0000_0001, 32'hffff_ffff);
    push_probe(32'h0000_8000, 32'h0000_8000);
    push_probe(32'hffff_ffff, 32'hffff_ffff);
    push_random(250);
    drain_pipe();

    // far corner center, huge radius: saturation on both axes
    write_reg(ccp_pkg::CFG_CENTER_X, 32'h8000_0000);
    write_reg(ccp_pkg::CFG_CENTER_Y, 32'h7fff_ffff);
    write_reg(ccp_pkg::CFG_RADIUS, 32'h7fff_ffff);
    push_probe(32'h8000_0000, 32'h7fff_ffff);
    push_probe(32'h7fff_ffff, 32'h8000_0000);
    push_probe(32'h0, 32'h0);
    push_probe(32'h7fff_ffff, 32'h7fff_ffff);
    gaps_on = 1'b0;
    push_random(250);
    drain_pipe();

    // zero radius, top bit of the radius word must be dropped
    gaps_on = 1'b1;
    write_reg(ccp_pkg::CFG_CENTER_X, 32'h7fff_ffff);
    write_reg(ccp_pkg::CFG_CENTER_Y, 32'h8000_0000);
    write_reg(ccp_pkg::CFG_RADIUS, 32'h8000_0000);
    write_reg(CFG_SPARE, 32'hdead_beef);
    push_probe(32'h7fff_ffff, 32'h8000_0000);
    push_probe(32'h8000_0000, 32'h7fff_ffff);
    push_probe(32'h7fff_fff0, 32'h8000_0010);
    push_random(250);
    drain_pipe();

    // random circles, radius kept moderate in the first two so near-circle probes matter
    for (int ph = 0; ph < 3; ph++) begin
      gaps_on = (ph != 1);
      write_reg(ccp_pkg::CFG_CENTER_X, $urandom);
      write_reg(ccp_pkg::CFG_CENTER_Y, $urandom);
      write_reg(ccp_pkg::CFG_RADIUS,
                (ph == 2) ? $urandom : $urandom_range(1, 32'h0100_0000));
      push_probe(32'(ctr_x), 32'(ctr_y));
      push_probe(32'(ctr_x + rad), 32'(ctr_y));
      push_random(280);
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/ccp_pkg.sv
src/ccp_front.sv
src/ccp_sqrt_step.sv
src/ccp_mid.sv
src/ccp_div_step.sv
src/circle_contain_and_project_core.sv
dv/circle_contain_and_project_core_tb.sv
